>>> sv/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
`default_nettype none

package pse_pkg;

	localparam int WORD_W = 32;

	typedef enum logic [2:0] {
		FN_PUSH = 3'd0,
		FN_ADD  = 3'd1,
		FN_SUB  = 3'd2,
		FN_MUL  = 3'd3,
		FN_DIV  = 3'd4,
		FN_REM  = 3'd5
	} func_t;

	typedef enum logic [1:0] {
		STS_OK      = 2'd0,
		STS_DIVZERO = 2'd1,
		STS_UNDER   = 2'd2,
		STS_OVER    = 2'd3
	} status_t;

	// token sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_WAIT
	} seq_state_t;

	// arithmetic unit sequencer
	typedef enum logic [1:0] {
		AS_IDLE,
		AS_DIV,
		AS_FIX,
		AS_DONE
	} alu_state_t;

	typedef struct packed {
		logic  start;
		func_t op;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic div_zero;
	} alu_rsp_t;

endpackage

`default_nettype wire

>>> sv/pse_alu.sv
// Shared arithmetic unit: add, subtract, multiply, and iterative divide/remainder.
`default_nettype none

module pse_alu import pse_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire alu_req_t          req,
	input  wire logic [WORD_W-1:0] a,
	input  wire logic [WORD_W-1:0] b,
	output alu_rsp_t               rsp,
	output logic [WORD_W-1:0]      result
);

	localparam int CNT_W = $clog2(WORD_W);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(WORD_W - 1);

	alu_state_t        state_q, state_d;
	logic [WORD_W-1:0] res_q;
	logic              dz_q;
	logic [WORD_W-1:0] quo_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] dvs_q;
	logic [CNT_W-1:0]  cnt_q;
	func_t             op_q;
	logic              negq_q;
	logic              negr_q;

	logic [WORD_W-1:0] a_mag, b_mag, quick, prod, shifted, diff;
	logic              is_div, b_zero, fits;

	assign is_div  = (req.op == FN_DIV) || (req.op == FN_REM);
	assign b_zero  = (b == '0);
	assign a_mag   = a[WORD_W-1] ? -a : a;
	assign b_mag   = b[WORD_W-1] ? -b : b;
	assign prod    = a * b;
	// remainder stays below the divisor, so its top bit is always clear
	assign shifted = {rem_q[WORD_W-2:0], quo_q[WORD_W-1]};
	assign fits    = (shifted >= dvs_q);
	assign diff    = shifted - dvs_q;

	always_comb begin
		case (req.op)
			FN_ADD:  quick = a + b;
			FN_SUB:  quick = a - b;
			FN_MUL:  quick = prod;
			default: quick = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			AS_IDLE: begin
				if (req.start)
					state_d = (is_div && !b_zero) ? AS_DIV : AS_DONE;
			end
			AS_DIV: begin
				if (cnt_q == CNT_LAST)
					state_d = AS_FIX;
			end
			AS_FIX:  state_d = AS_DONE;
			AS_DONE: state_d = AS_IDLE;
			default: state_d = AS_IDLE;
		endcase
	end

	always_comb begin
		rsp.done     = (state_q == AS_DONE);
		rsp.div_zero = dz_q;
		result       = res_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= AS_IDLE;
		else
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		case (state_q)
			AS_IDLE: begin
				if (req.start) begin
					res_q  <= quick;
					dz_q   <= is_div && b_zero;
					op_q   <= req.op;
					quo_q  <= a_mag;
					rem_q  <= '0;
					dvs_q  <= b_mag;
					cnt_q  <= '0;
					negq_q <= a[WORD_W-1] ^ b[WORD_W-1];
					negr_q <= a[WORD_W-1];
				end
			end
			AS_DIV: begin
				rem_q <= fits ? diff : shifted;
				quo_q <= {quo_q[WORD_W-2:0], fits};
				cnt_q <= cnt_q + CNT_W'(1);
			end
			AS_FIX: begin
				if (op_q == FN_DIV)
					res_q <= negq_q ? -quo_q : quo_q;
				else
					res_q <= negr_q ? -rem_q : rem_q;
			end
			default: ;
		endcase
	end

endmodule

`default_nettype wire

>>> sv/postfix_stack_evaluator.sv
// Postfix (RPN) integer expression evaluator: one token per request.
// Push and unused tokens finish when accepted; add, subtract and multiply
// pass through the shared arithmetic unit; divide and remainder with a nonzero
// divisor also run its radix-2 divide loop (one quotient bit a cycle).
// Throughput: one token at a time; the result register lets the next token in.
// Reset (arst_n, async low) empties the stack and clears the sticky status.
`default_nettype none

module postfix_stack_evaluator import pse_pkg::*; #(
	parameter int STACK_DEPTH = 64
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// token requests
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic [2:0]        func,
	input  wire logic [WORD_W-1:0] number,
	input  wire logic              last_token,
	// result requests
	output logic                   out_valid,
	input  wire logic              out_stall,
	output logic [WORD_W-1:0]      value,
	output logic [1:0]             status
);

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam logic [CW-1:0] CNT_FULL = CW'(STACK_DEPTH);

	// Stack layout: the top entry lives in top_q; everything below it sits
	// in stack_mem, so entry k (0 = bottom) is at address k while not on top.
	logic [WORD_W-1:0] stack_mem [STACK_DEPTH];
	logic [WORD_W-1:0] rd_data_q;
	logic [WORD_W-1:0] top_q, top_d;
	logic [CW-1:0]     count_q, cnt_d;
	status_t           err_q, err_d;
	seq_state_t        state_q, state_d;
	logic              last_q;
	func_t             op_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] value_q;
	status_t           status_q;

	func_t             fn;
	logic              accept, emit, wr_en;
	logic              is_op, op_ok;
	logic [CW-1:0]     cnt_m1, cnt_m2;
	logic [AW-1:0]     wr_addr, rd_addr;

	alu_req_t          alu_req;
	alu_rsp_t          alu_rsp;
	logic [WORD_W-1:0] alu_res;

	assign fn      = func_t'(func);
	assign accept  = in_valid && !in_stall;
	assign is_op   = fn inside {[FN_ADD:FN_REM]};
	assign op_ok   = (count_q >= CW'(2));
	assign cnt_m1  = count_q - CW'(1);
	assign cnt_m2  = count_q - CW'(2);
	// push spills the old top to the slot just under the new one
	assign wr_addr = cnt_m1[AW-1:0];
	// left operand sits just under the top
	assign rd_addr = cnt_m2[AW-1:0];

	// ---------------- sequencer: next state ----------------
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && is_op && op_ok)
					state_d = ST_LOAD;
			end
			ST_LOAD: state_d = ST_WAIT;
			ST_WAIT: begin
				if (alu_rsp.done)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// ---------------- sequencer: outputs ----------------
	// Every token waits while an operator is in progress. A last token also waits
	// while an older result still sits in the output register; others go ahead.
	always_comb begin
		in_stall      = (state_q != ST_IDLE) || (out_valid_q && last_token);
		alu_req.start = (state_q == ST_LOAD);
		alu_req.op    = op_q;
	end

	// ---------------- stack and status update ----------------
	always_comb begin
		cnt_d = count_q;
		top_d = top_q;
		err_d = err_q;
		wr_en = 1'b0;
		emit  = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (fn == FN_PUSH) begin
						if (count_q >= CNT_FULL) begin
							if (err_q == STS_OK)
								err_d = STS_OVER;
						end else begin
							wr_en = (count_q != '0);
							top_d = number;
							cnt_d = count_q + CW'(1);
						end
					end else if (is_op && !op_ok) begin
						if (err_q == STS_OK)
							err_d = STS_UNDER;
					end
					// operators with enough operands finish in ST_WAIT
					emit = last_token && !(is_op && op_ok);
				end
			end
			ST_WAIT: begin
				if (alu_rsp.done) begin
					top_d = alu_res;
					cnt_d = cnt_m1;
					if (alu_rsp.div_zero && (err_q == STS_OK))
						err_d = STS_DIVZERO;
					emit = last_q;
				end
			end
			default: ;
		endcase
	end

	pse_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (alu_req),
		.a      (rd_data_q),
		.b      (top_q),
		.rsp    (alu_rsp),
		.result (alu_res)
	);

	// operand stack memory: one write, one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en)
			stack_mem[wr_addr] <= top_q;
		rd_data_q <= stack_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			err_q       <= STS_OK;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// end of expression empties the stack and clears the sticky status
			count_q <= emit ? '0 : cnt_d;
			err_q   <= emit ? STS_OK : err_d;
			if (emit)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		if (accept) begin
			last_q <= last_token;
			op_q   <= fn;
		end
		if (emit) begin
			value_q  <= (cnt_d != '0) ? top_d : '0;
			status_q <= err_d;
		end
	end

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign status    = status_q;

	// ---------------- assertions ----------------
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_FULL)
		else $error("stack count beyond depth");

	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		alu_rsp.done |-> (state_q == ST_WAIT))
		else $error("arithmetic unit finished outside wait state");

	a_emit_slot_free: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> !out_valid_q)
		else $error("result produced while output register full");

	a_emit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (count_q == '0) && (err_q == STS_OK) && out_valid_q)
		else $error("stack not emptied after last token");

endmodule

`default_nettype wire
